### hw/rtl/dmx512_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// DMX512 frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk_i and masked in reset.
// ----------------------------------------------------------------------------
`ifndef DMX512_FRAME_RECEIVER_DEFINES_SVH
`define DMX512_FRAME_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dmx_pkg.sv
// ----------------------------------------------------------------------------
// DMX512 frame receiver package
// Word types, command and register codes and reset values.
// ----------------------------------------------------------------------------
package dmx_pkg;

  localparam int unsigned SLOT_W = 10;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned CHG_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_BYTE = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MAX = 1'b1;

  localparam logic [CFG_W-1:0] BREAK_MIN_RST = 24'd88;
  localparam logic [CFG_W-1:0] BREAK_MAX_RST = 24'd1000000;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              line_high;
    logic [DATA_W-1:0] rx_byte;
    logic              rx_error;
    logic [SLOT_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic              break_seen;
    logic              slot_written;
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] read_value;
    logic [CHG_W-1:0]  change_count;
    logic [CFG_W-1:0]  last_break_us;
  } out_item_t;

  // Result of an accepted word while the slot store read is in flight.
  typedef struct packed {
    logic              break_seen;
    logic              slot_written;
    logic [SLOT_W-1:0] slot_index;
    logic              rd_ok;
    logic [CHG_W-1:0]  change_count;
    logic [CFG_W-1:0]  last_break_us;
  } stage_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage

### hw/rtl/dmx_if.sv
// ----------------------------------------------------------------------------
// DMX512 frame receiver channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface dmx_in_if;
  import dmx_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dmx_out_if;
  import dmx_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/dmx_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dmx_ctrl.sv
// ----------------------------------------------------------------------------
// DMX512 frame receiver control
// Break timing, frame sum, change counter, slot pointer and store requests.
// ----------------------------------------------------------------------------
module dmx_ctrl #(
  parameter int unsigned SLOTS     = 513,
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  dmx_pkg::in_item_t               item_i,
  input  logic                            cfg_we_i,
  input  logic [dmx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dmx_pkg::CFG_W-1:0]       cfg_data_i,
  output dmx_pkg::ram_req_t               ram_req_o,
  output dmx_pkg::stage_t                 stage_o
);
  import dmx_pkg::*;

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CMP_W = 32;

  logic [CFG_W-1:0]     min_q, max_q;
  logic [TIME_BITS-1:0] low_q, low_d;
  logic [AW-1:0]        slot_q, slot_d;
  logic [DATA_W-1:0]    sum_q, sum_d;
  logic [DATA_W-1:0]    prev_q, prev_d;
  logic [CHG_W-1:0]     chg_q, chg_d;
  logic [CFG_W-1:0]     blen_q, blen_d;

  cmd_e cmd;
  logic in_win;
  logic rd_ok;
  logic byte_ok;

  assign cmd     = cmd_e'(item_i.cmd);
  assign in_win  = (CMP_W'(low_q) >= CMP_W'(min_q)) && (CMP_W'(low_q) <= CMP_W'(max_q));
  assign rd_ok   = ({1'b0, item_i.read_index} < (SLOT_W + 1)'(SLOTS));
  assign byte_ok = (cmd == CMD_BYTE) && !item_i.rx_error;

  always_comb begin
    low_d  = low_q;
    slot_d = slot_q;
    sum_d  = sum_q;
    prev_d = prev_q;
    chg_d  = chg_q;
    blen_d = blen_q;
    stage_o = '0;
    unique case (cmd)
      CMD_TICK: begin
        if (!(&low_q)) begin
          low_d = low_q + 1'b1;
        end
      end
      CMD_EDGE: begin
        if (!item_i.line_high) begin
          low_d = '0;
        end else if (in_win) begin
          if (prev_q != sum_q) begin
            chg_d = chg_q + 1'b1;
          end
          prev_d = sum_q;
          sum_d  = '0;
          blen_d = CFG_W'(low_q);
          slot_d = '0;
          stage_o.break_seen = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (!item_i.rx_error) begin
          sum_d = sum_q + item_i.rx_byte;
          stage_o.slot_written = 1'b1;
          stage_o.slot_index   = SLOT_W'(slot_q);
          slot_d = (slot_q == AW'(SLOTS - 1)) ? '0 : slot_q + 1'b1;
        end
      end
      CMD_READ: begin
        stage_o.rd_ok = rd_ok;
      end
      default: begin
      end
    endcase
    stage_o.change_count  = chg_d;
    stage_o.last_break_us = blen_d;
  end

  always_comb begin
    ram_req_o.we    = acc_i && byte_ok;
    ram_req_o.waddr = SLOT_W'(slot_q);
    ram_req_o.wdata = item_i.rx_byte;
    ram_req_o.re    = acc_i && (cmd == CMD_READ) && rd_ok;
    ram_req_o.raddr = item_i.read_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      slot_q <= '0;
      sum_q  <= '0;
      prev_q <= '0;
      chg_q  <= '0;
      blen_q <= '0;
    end else if (acc_i) begin
      low_q  <= low_d;
      slot_q <= slot_d;
      sum_q  <= sum_d;
      prev_q <= prev_d;
      chg_q  <= chg_d;
      blen_q <= blen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= BREAK_MIN_RST;
      max_q <= BREAK_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BREAK_MIN: min_q <= cfg_data_i;
        REG_BREAK_MAX: max_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/dmx512_frame_receiver.sv
// ----------------------------------------------------------------------------
// DMX512 frame receiver
// Break detection, frame change counting and a slot store with read-back.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  in_i      sink       tick, line edge, received byte or slot read
//  out_o     source     one result word for every input word
//  cfg       write      break window limits, index 0 minimum, 1 maximum
//
// One input word is taken every cycle unless output stalls; its result word passes
// s1 and then out_q, the slot store being read at the accepting edge itself.
// Reset clears all counters and restores the break window; the slot store is
// not cleared and needs no pass after reset.
// A result word held at the output stalls input only once the stage behind it
// is full as well.
module dmx512_frame_receiver #(
  parameter int unsigned SLOTS     = 513,
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dmx_in_if.sink                        in_i,
  dmx_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [dmx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmx_pkg::CFG_W-1:0]     cfg_data_i
);
  import dmx_pkg::*;

  `include "dmx512_frame_receiver_defines.svh"

  localparam int unsigned AW = $clog2(SLOTS);

  logic      in_acc;
  logic      adv;
  ram_req_t  ram_req;
  stage_t    stage;
  logic [DATA_W-1:0] rdata;

  logic      s1_q, s1_d;
  stage_t    s1_pay_q;
  logic      ov_q, ov_d;
  out_item_t out_q;

  assign adv        = s1_q && (!ov_q || out_o.ready);
  assign in_i.ready = !s1_q || !ov_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  dmx_ctrl #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .item_i     (in_i.item),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ram_req_o  (ram_req),
    .stage_o    (stage)
  );

  dmx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr[AW-1:0]),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_d = s1_q;
    if (in_acc) begin
      s1_d = 1'b1;
    end else if (adv) begin
      s1_d = 1'b0;
    end
    ov_d = ov_q;
    if (adv) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      s1_q <= s1_d;
      ov_q <= ov_d;
    end
  end

  // The read data stays put while the stage waits, since no read is issued then.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pay_q <= stage;
    end
    if (adv) begin
      out_q.break_seen    <= s1_pay_q.break_seen;
      out_q.slot_written  <= s1_pay_q.slot_written;
      out_q.slot_index    <= s1_pay_q.slot_index;
      out_q.read_value    <= s1_pay_q.rd_ok ? rdata : '0;
      out_q.change_count  <= s1_pay_q.change_count;
      out_q.last_break_us <= s1_pay_q.last_break_us;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.item  = out_q;

  `DMX_ASSERT_NXT(a_acc_fills_stage, in_acc, s1_q, "accepted word did not reach the stage")
  `DMX_ASSERT_IMP(a_read_held, s1_q && !adv, !ram_req.re, "store read issued while stage stalled")
  `DMX_ASSERT_IMP(a_slot_range, out_o.valid && out_o.item.slot_written, ({1'b0, out_o.item.slot_index} < (SLOT_W + 1)'(SLOTS)), "stored slot index out of range")

endmodule

### verif/dmx512_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 frame receiver testbench
// Drives ticks, line edges, received bytes and slot reads with random gaps,
// predicts every result word and checks the result stream field by field.
// ----------------------------------------------------------------------------
module dmx512_frame_receiver_tb;
  import dmx_pkg::*;

  localparam int SLOTS        = 513;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  dmx_in_if  in_ch ();
  dmx_out_if out_ch ();

  dmx512_frame_receiver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver state as the testbench sees it.
  logic [CFG_W-1:0]  win_min = BREAK_MIN_RST;
  logic [CFG_W-1:0]  win_max = BREAK_MAX_RST;
  logic [23:0]       low_ticks = '0;
  logic [SLOT_W-1:0] slot_ptr = '0;
  logic [7:0]        slot_mem [0:SLOTS-1];
  bit                slot_filled [0:SLOTS-1];
  int                filled_list[$];
  logic [7:0]        sum_now = '0;
  logic [7:0]        sum_prev = '0;
  logic [31:0]       changes = '0;
  logic [23:0]       brk_len = '0;

  out_item_t  owed_results[$];
  logic [7:0] last_frame[$];
  int         items_sent = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         random_base;

  int tx_run = 0;
  bit tx_calm = 1'b0;
  int rx_run = 0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;

  function automatic int draw_wait(inout int run, inout bit calm);
    if (run == 0) begin
      run  = $urandom_range(4, 40);
      calm = ($urandom_range(0, 2) == 0);
    end
    run--;
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Applies one input word to the predicted state and returns its result word.
  function automatic out_item_t dmx_receive(in_item_t w);
    out_item_t r;
    r = '0;
    case (w.cmd)
      CMD_TICK: begin
        if (low_ticks != '1) low_ticks++;
      end
      CMD_EDGE: begin
        if (!w.line_high) begin
          low_ticks = '0;
        end else if (low_ticks >= win_min && low_ticks <= win_max) begin
          if (sum_prev != sum_now) changes++;
          sum_prev     = sum_now;
          sum_now      = '0;
          brk_len      = low_ticks;
          slot_ptr     = '0;
          r.break_seen = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (!w.rx_error) begin
          sum_now            = sum_now + w.rx_byte;
          slot_mem[slot_ptr] = w.rx_byte;
          if (!slot_filled[slot_ptr]) begin
            slot_filled[slot_ptr] = 1'b1;
            filled_list.push_back(int'(slot_ptr));
          end
          r.slot_written = 1'b1;
          r.slot_index   = slot_ptr;
          slot_ptr       = (slot_ptr == SLOTS - 1) ? '0 : slot_ptr + 1'b1;
        end
      end
      CMD_READ: begin
        if (w.read_index < SLOTS) r.read_value = slot_mem[w.read_index];
      end
    endcase
    r.change_count  = changes;
    r.last_break_us = brk_len;
    return r;
  endfunction

  task automatic send_word(in_item_t w);
    int gap;
    gap = draw_wait(tx_run, tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.item  <= w;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    owed_results.push_back(dmx_receive(w));
    items_sent++;
    @(negedge clk_i);
  endtask

  // Fields that the command does not use carry random bits.
  function automatic in_item_t noise_word(cmd_e c);
    logic [$bits(in_item_t)-1:0] raw;
    in_item_t w;
    raw   = ($bits(in_item_t))'($urandom);
    w     = raw;
    w.cmd = c;
    return w;
  endfunction

  task automatic put_tick();
    send_word(noise_word(CMD_TICK));
  endtask

  task automatic put_edge(logic hi);
    in_item_t w;
    w           = noise_word(CMD_EDGE);
    w.line_high = hi;
    send_word(w);
  endtask

  task automatic put_byte(logic [7:0] b, logic err);
    in_item_t w;
    w          = noise_word(CMD_BYTE);
    w.rx_byte  = b;
    w.rx_error = err;
    send_word(w);
  endtask

  task automatic put_read(logic [SLOT_W-1:0] idx);
    in_item_t w;
    w            = noise_word(CMD_READ);
    w.read_index = idx;
    send_word(w);
  endtask

  // Reads go to slots already written or beyond the store, never elsewhere.
  function automatic logic [SLOT_W-1:0] pick_read_index();
    if (filled_list.size() == 0 || $urandom_range(0, 4) == 0)
      return SLOT_W'($urandom_range(SLOTS, 1023));
    return SLOT_W'(filled_list[$urandom_range(0, filled_list.size() - 1)]);
  endfunction

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    if (idx == REG_BREAK_MIN) win_min = value;
    else win_max = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_window(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    settle();
    cfg_write(REG_BREAK_MIN, lo);
    cfg_write(REG_BREAK_MAX, hi);
  endtask

  // One frame: an optional glitch, the break, then bytes with stray words mixed in.
  task automatic run_frame();
    logic [7:0]  data[$];
    logic [23:0] n;
    logic [23:0] span;
    bit          reuse;
    reuse = ($urandom_range(0, 3) == 0) && (last_frame.size() != 0);
    if ($urandom_range(0, 4) == 0) begin
      put_edge(1'b0);
      repeat ($urandom_range(0, 1)) put_tick();
      put_edge(1'b1);
    end
    put_edge(1'b0);
    if (win_min <= win_max && win_min <= 200 && $urandom_range(0, 3) != 0) begin
      span = win_max - win_min;
      n    = win_min + CFG_W'($urandom_range(0, (span > 30) ? 30 : span));
    end else begin
      n = 24'($urandom_range(0, 40));
    end
    repeat (n) put_tick();
    put_edge(1'b1);
    // Repeating the last frame's bytes gives an unchanged sum.
    if (reuse) data = last_frame;
    else repeat ($urandom_range(0, 14)) data.push_back(8'($urandom));
    foreach (data[i]) begin
      case ($urandom_range(0, 9))
        0: put_tick();
        1: put_read(pick_read_index());
        2: put_byte(8'($urandom), 1'b1);
        default: ;
      endcase
      put_byte(data[i], 1'b0);
    end
    last_frame = data;
    if ($urandom_range(0, 9) == 0) put_edge(1'b1);
  endtask

  task automatic test_default_window();
    put_read(SLOT_W'($urandom_range(SLOTS, 1023)));
    put_edge(1'b1);
    put_byte(8'h3C, 1'b1);
    put_edge(1'b0);
    repeat (87) put_tick();
    put_edge(1'b1);
    put_edge(1'b0);
    repeat (88) put_tick();
    put_edge(1'b1);
    put_byte(8'h81, 1'b0);
    put_byte(8'h7E, 1'b0);
    put_read('0);
  endtask

  task automatic test_directed();
    set_window(24'd2, 24'd4);
    put_tick();
    put_edge(1'b0);
    put_tick();
    put_tick();
    put_edge(1'b1);
    // No falling edge in between, so the same low time counts again.
    put_edge(1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hA5, 1'b0);
    put_byte(8'h5A, 1'b1);
    put_read(10'd0);
    put_read(10'd2);
    put_read(10'd513);
    put_read(10'd1023);
    put_edge(1'b0);
    repeat (5) put_tick();
    put_edge(1'b1);
    put_edge(1'b0);
    put_edge(1'b1);
    put_edge(1'b0);
    repeat (4) put_tick();
    put_edge(1'b1);
  endtask

  task automatic test_window_extremes();
    set_window('0, '0);
    repeat (4) run_frame();
    set_window('1, '1);
    repeat (3) run_frame();
    set_window('0, '1);
    repeat (4) run_frame();
    set_window(24'd10, 24'd3);
    repeat (3) run_frame();
    set_window(24'd7, 24'd7);
    repeat (4) run_frame();
  endtask

  task automatic test_slot_wrap();
    set_window(24'd1, 24'd8);
    put_edge(1'b0);
    repeat (3) put_tick();
    put_edge(1'b1);
    for (int i = 0; i < SLOTS + 7; i++) begin
      if ($urandom_range(0, 15) == 0) put_byte(8'($urandom), 1'b1);
      put_byte(8'($urandom), 1'b0);
    end
    put_read(10'd512);
    put_read(10'd0);
    repeat (4) put_read(pick_read_index());
  endtask

  task automatic test_random_frames(int stop_at);
    logic [CFG_W-1:0] lo;
    while (items_sent < stop_at) begin
      lo = CFG_W'($urandom_range(0, 20));
      if ($urandom_range(0, 5) == 0) set_window(lo + CFG_W'(5), lo);
      else set_window(lo, lo + CFG_W'($urandom_range(0, 25)));
      repeat ($urandom_range(4, 12)) run_frame();
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      out_ch.ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic note_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%s mismatch: expected %0h, got %0h", what, want_v, got_v);
  endtask

  always @(posedge clk_i) begin : check_result
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got     = out_ch.item;
      rx_wait = draw_wait(rx_run, rx_calm);
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected: %h", got);
      end else begin
        want = owed_results.pop_front();
        if (got.break_seen !== want.break_seen)
          note_mismatch("break_seen", want.break_seen, got.break_seen);
        if (got.slot_written !== want.slot_written)
          note_mismatch("slot_written", want.slot_written, got.slot_written);
        if (got.slot_index !== want.slot_index)
          note_mismatch("slot_index", want.slot_index, got.slot_index);
        if (got.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, got.read_value);
        if (got.change_count !== want.change_count)
          note_mismatch("change_count", want.change_count, got.change_count);
        if (got.last_break_us !== want.last_break_us)
          note_mismatch("last_break_us", want.last_break_us, got.last_break_us);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_window();
    test_directed();
    random_base = items_sent;
    test_window_extremes();
    test_slot_wrap();
    test_random_frames(random_base + RANDOM_ITEMS);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dmx_pkg.sv
hw/rtl/dmx_if.sv
hw/rtl/dmx_ram.sv
hw/rtl/dmx_ctrl.sv
hw/rtl/dmx512_frame_receiver.sv
verif/dmx512_frame_receiver_tb.sv
